### src/rcw_pkg.sv
// Shared types, constants and MD5 tables for the rainbow chain walk block.
package rcw_pkg;

	localparam int MAX_ALPHABET = 32;
	localparam int MAX_LEN      = 8;
	localparam int MAX_CHAIN    = 1024;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_CHARS_LO  = 3'd0;
	localparam logic [2:0] REG_CHARS_MID = 3'd1;
	localparam logic [2:0] REG_CHARS_HI  = 3'd2;
	localparam logic [2:0] REG_CHARS_TOP = 3'd3;
	localparam logic [2:0] REG_COUNT     = 3'd4;
	localparam logic [2:0] REG_MIN_LEN   = 3'd5;
	localparam logic [2:0] REG_MAX_LEN   = 3'd6;
	localparam logic [2:0] REG_SPACE     = 3'd7;

	// Datapath operations.
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_INIT = 4'd2;
	localparam logic [3:0] OP_POW  = 4'd3;
	localparam logic [3:0] OP_LSEL = 4'd4;
	localparam logic [3:0] OP_DIV  = 4'd5;
	localparam logic [3:0] OP_MD5  = 4'd6;
	localparam logic [3:0] OP_SUM  = 4'd7;
	localparam logic [3:0] OP_MOD  = 4'd8;
	localparam logic [3:0] OP_NEXT = 4'd9;

	typedef struct packed {
		logic [255:0] chars;
		logic [5:0]   cnt;
		logic [3:0]   lo;
		logic [3:0]   hi;
		logic [62:0]  modulus;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [5:0]  step;
		logic [2:0]  digit;
		logic [10:0] link;
	} cmd_t;

	typedef struct packed {
		logic       pow_done;
		logic       stop;
		logic [3:0] len;
	} status_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// Message word index for each round.
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'((5 * int'(i)) + 1);
			2'd2: g = 4'((3 * int'(i)) + 5);
			default: g = 4'(7 * int'(i));
		endcase
		return g;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] w;
		w = {x, x} << s;
		return w[63:32];
	endfunction

endpackage

### src/rcw_regs.sv
// Configuration register file with APB-style access and range clamping.
module rcw_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output rcw_pkg::cfg_t      cfg
);
	import rcw_pkg::*;

	logic [63:0] chars_q [4];
	logic [5:0]  count_q;
	logic [3:0]  min_len_q;
	logic [3:0]  max_len_q;
	logic [62:0] space_q;
	logic        wr;
	logic [2:0]  idx;
	logic [3:0]  lo;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) chars_q[i] <= '0;
			count_q   <= 6'd1;
			min_len_q <= 4'd1;
			max_len_q <= 4'd1;
			space_q   <= 63'd1;
		end else if (wr) begin
			case (idx)
				REG_CHARS_LO:  chars_q[0] <= pwdata;
				REG_CHARS_MID: chars_q[1] <= pwdata;
				REG_CHARS_HI:  chars_q[2] <= pwdata;
				REG_CHARS_TOP: chars_q[3] <= pwdata;
				REG_COUNT:     count_q    <= pwdata[5:0];
				REG_MIN_LEN:   min_len_q  <= pwdata[3:0];
				REG_MAX_LEN:   max_len_q  <= pwdata[3:0];
				REG_SPACE:     space_q    <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CHARS_LO:  prdata = chars_q[0];
			REG_CHARS_MID: prdata = chars_q[1];
			REG_CHARS_HI:  prdata = chars_q[2];
			REG_CHARS_TOP: prdata = chars_q[3];
			REG_COUNT:     prdata = {58'd0, count_q};
			REG_MIN_LEN:   prdata = {60'd0, min_len_q};
			REG_MAX_LEN:   prdata = {60'd0, max_len_q};
			REG_SPACE:     prdata = {1'b0, space_q};
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		cfg.chars = {chars_q[3], chars_q[2], chars_q[1], chars_q[0]};
		if (count_q == 6'd0) cfg.cnt = 6'd1;
		else if (count_q > 6'(MAX_ALPHABET)) cfg.cnt = 6'(MAX_ALPHABET);
		else cfg.cnt = count_q;
		if (min_len_q == 4'd0) lo = 4'd1;
		else if (min_len_q > 4'(MAX_LEN)) lo = 4'(MAX_LEN);
		else lo = min_len_q;
		cfg.lo = lo;
		if (max_len_q > 4'(MAX_LEN)) cfg.hi = 4'(MAX_LEN);
		else if (max_len_q < lo) cfg.hi = lo;
		else cfg.hi = max_len_q;
		cfg.modulus = (space_q == 63'd0) ? 63'd1 : space_q;
	end
endmodule

### src/rcw_ctrl.sv
// Sequencer for the chain walk: phases of each link and the link count.
module rcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [10:0]        chain_length,
	input  rcw_pkg::status_t   st,
	output rcw_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import rcw_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_POW  = 4'd2;
	localparam logic [3:0] S_LSEL = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_MD5  = 4'd5;
	localparam logic [3:0] S_SUM  = 4'd6;
	localparam logic [3:0] S_MOD  = 4'd7;
	localparam logic [3:0] S_NEXT = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]  state_q;
	logic [5:0]  step_q;
	logic [2:0]  digit_q;
	logic [10:0] link_q;
	logic [10:0] links_q;
	logic [10:0] links_c;

	assign links_c = (chain_length > 11'(MAX_CHAIN)) ? 11'(MAX_CHAIN) : chain_length;
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		cmd.step  = step_q;
		cmd.digit = digit_q;
		cmd.link  = link_q;
		case (state_q)
			S_IDLE:  cmd.op = start ? OP_LOAD : OP_NONE;
			S_INIT:  cmd.op = OP_INIT;
			S_POW:   cmd.op = st.pow_done ? OP_NONE : OP_POW;
			S_LSEL:  cmd.op = st.stop ? OP_NONE : OP_LSEL;
			S_DIV:   cmd.op = OP_DIV;
			S_MD5:   cmd.op = OP_MD5;
			S_SUM:   cmd.op = OP_SUM;
			S_MOD:   cmd.op = OP_MOD;
			S_NEXT:  cmd.op = OP_NEXT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			digit_q <= '0;
			link_q  <= '0;
			links_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						links_q <= links_c;
						link_q  <= 11'd1;
						state_q <= (links_c <= 11'd1) ? S_DONE : S_INIT;
					end
				end
				S_INIT: state_q <= S_POW;
				S_POW: begin
					if (st.pow_done) state_q <= S_LSEL;
				end
				S_LSEL: begin
					if (st.stop) begin
						state_q <= S_DIV;
						step_q  <= '0;
						digit_q <= '0;
					end
				end
				S_DIV: begin
					// Four quotient bits per step; a digit is complete after step 15.
					if (step_q[3:0] == 4'd15) begin
						step_q <= '0;
						if ({1'b0, digit_q} == st.len - 4'd1) begin
							digit_q <= '0;
							state_q <= S_MD5;
						end else begin
							digit_q <= digit_q + 3'd1;
						end
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				S_MD5: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) state_q <= S_SUM;
				end
				S_SUM: begin
					step_q  <= '0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (link_q == links_q - 11'd1) begin
						state_q <= S_DONE;
					end else begin
						link_q  <= link_q + 11'd1;
						state_q <= S_INIT;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/rcw_dpath.sv
// Datapath: length selection, digit divider, MD5 rounds and final modulo.
module rcw_dpath (
	input  logic               clk,
	input  rcw_pkg::cfg_t      cfg,
	input  rcw_pkg::cmd_t      cmd,
	input  logic [62:0]        start_index,
	output rcw_pkg::status_t   st,
	output logic [62:0]        end_index
);
	import rcw_pkg::*;

	logic [62:0] idx_q;
	logic [62:0] rest_q;
	logic [40:0] pow_q;
	logic [3:0]  len_q;
	logic [3:0]  exp_q;
	logic [7:0]  cand_q [8];
	logic [63:0] dq_q;
	logic [4:0]  r_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] x_q;
	logic [63:0] mr_q;

	logic [46:0] pow_mul;
	logic [63:0] dq_n;
	logic [5:0]  r_t;
	logic [4:0]  r_n;
	logic [2:0]  cpos;
	logic [7:0]  ch;
	logic [31:0] msg [16];
	logic [7:0]  bt;
	logic [31:0] ca, cb, cc, cd, fv, fsum, nb;
	logic [63:0] mr_in, mr_sh, mr_n;

	assign end_index   = idx_q;
	assign st.len      = len_q;
	assign st.pow_done = (exp_q == len_q);
	assign st.stop     = ({22'd0, pow_q} > rest_q) || (len_q >= cfg.hi);
	assign pow_mul     = pow_q * cfg.cnt;

	// Radix-16 restoring division of the rest by the alphabet count.
	always_comb begin
		dq_n = (cmd.step[3:0] == 4'd0) ? {1'b0, rest_q} : dq_q;
		r_n  = (cmd.step[3:0] == 4'd0) ? 5'd0 : r_q;
		for (int i = 0; i < 4; i++) begin
			r_t = {r_n, dq_n[63]};
			if (r_t >= cfg.cnt) begin
				r_t  = r_t - cfg.cnt;
				dq_n = {dq_n[62:0], 1'b1};
			end else begin
				dq_n = {dq_n[62:0], 1'b0};
			end
			r_n = r_t[4:0];
		end
		cpos = 3'(len_q - 4'd1 - {1'b0, cmd.digit});
		ch   = cfg.chars[{r_n, 3'b000} +: 8];
	end

	// One-block message: candidate bytes, the pad byte and the bit length.
	always_comb begin
		for (int w = 0; w < 16; w++) msg[w] = '0;
		for (int j = 0; j < 16; j++) begin
			bt = 8'h00;
			if (j < int'(len_q)) bt = cand_q[j % 8];
			else if (j == int'(len_q)) bt = 8'h80;
			msg[j / 4][8 * (j % 4) +: 8] = bt;
		end
		msg[14] = {25'd0, len_q, 3'b000};
	end

	always_comb begin
		ca = (cmd.step == 6'd0) ? IV_A : a_q;
		cb = (cmd.step == 6'd0) ? IV_B : b_q;
		cc = (cmd.step == 6'd0) ? IV_C : c_q;
		cd = (cmd.step == 6'd0) ? IV_D : d_q;
		case (cmd.step[5:4])
			2'd0: fv = (cb & cc) | (~cb & cd);
			2'd1: fv = (cd & cb) | (~cd & cc);
			2'd2: fv = cb ^ cc ^ cd;
			default: fv = cc ^ (cb | ~cd);
		endcase
		fsum = fv + ca + md5_k(cmd.step) + msg[md5_g(cmd.step)];
		nb   = cb + rotl32(fsum, md5_s(cmd.step));
	end

	// Bit-serial remainder of the digest sum by the space size.
	always_comb begin
		mr_in = (cmd.step == 6'd0) ? 64'd0 : mr_q;
		mr_sh = {mr_in[62:0], x_q[63]};
		mr_n  = (mr_sh >= {1'b0, cfg.modulus}) ? mr_sh - {1'b0, cfg.modulus} : mr_sh;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: idx_q <= start_index;
			OP_INIT: begin
				rest_q <= idx_q;
				len_q  <= cfg.lo;
				pow_q  <= 41'd1;
				exp_q  <= 4'd0;
			end
			OP_POW: begin
				pow_q <= pow_mul[40:0];
				exp_q <= exp_q + 4'd1;
			end
			OP_LSEL: begin
				rest_q <= rest_q - {22'd0, pow_q};
				pow_q  <= pow_mul[40:0];
				len_q  <= len_q + 4'd1;
			end
			OP_DIV: begin
				dq_q <= dq_n;
				r_q  <= r_n;
				if (cmd.step[3:0] == 4'd15) begin
					rest_q       <= dq_n[62:0];
					cand_q[cpos] <= ch;
				end
			end
			OP_MD5: begin
				a_q <= cd;
				d_q <= cc;
				c_q <= cb;
				b_q <= nb;
			end
			OP_SUM: x_q <= {b_q + IV_B, a_q + IV_A} + {53'd0, cmd.link};
			OP_MOD: begin
				mr_q <= mr_n;
				x_q  <= {x_q[62:0], 1'b0};
			end
			OP_NEXT: idx_q <= mr_q[62:0];
			default: ;
		endcase
	end
endmodule

### src/rainbow_chain_walk_md5.sv
// Top level of the MD5 rainbow chain walk: registers, sequencer and datapath.
//
//  channel   direction  handshake                 payload
//  command   in         start, busy               start_index, chain_length
//  result    out        done (one-cycle strobe)   end_index
//  config    in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A chain of L links (L = chain_length - 1, chain_length capped at 1024) shows its result
// beat after each link has run, in order, its setup, the power and length-selection phases,
// the divider for each digit of the link's candidate, 64 MD5 rounds, the digest sum and the
// bit-serial modulo.
// Busy stays high through the result cycle, so the next beat is taken in the cycle after it at the earliest.
// Reset is asynchronous and active low; no clearing pass is needed.
// The result strobe lasts one cycle and the receiver cannot stall it.
module rainbow_chain_walk_md5 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [62:0] start_index,
	input  logic [10:0] chain_length,
	output logic        done,
	output logic [62:0] end_index,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import rcw_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;

	assign pready = 1'b1;

	rcw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rcw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.chain_length (chain_length),
		.st           (st),
		.cmd          (cmd),
		.busy         (busy),
		.done         (done)
	);

	rcw_dpath u_dpath (
		.clk         (clk),
		.cfg         (cfg),
		.cmd         (cmd),
		.start_index (start_index),
		.st          (st),
		.end_index   (end_index)
	);
endmodule

### src/rcw_checker.sv
// Port-level checks for the chain walk, bound to the top level.
module rcw_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command beat did not raise busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat while idle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result beat");
endmodule

bind rainbow_chain_walk_md5 rcw_checker u_rcw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

### tb/sv/tb.sv
// Testbench for the MD5 rainbow chain walk: drives command beats and register writes,
// predicts each end index and checks the result stream.
class chain_scoreboard;
	bit [63:0] chars[4];
	bit [5:0]  count_reg;
	bit [3:0]  min_len_reg;
	bit [3:0]  max_len_reg;
	bit [62:0] space_reg;
	bit [31:0] md5_const[64];
	bit [62:0] expected_ends[$];
	int        fails;

	function new();
		real r;
		for (int i = 0; i < 64; i++) begin
			r = $sin(i + 1);
			if (r < 0.0) begin
				r = -r;
			end
			md5_const[i] = 32'(longint'($floor(r * 4294967296.0)));
		end
		chars = '{default: 64'd0};
		count_reg = 6'd1;
		min_len_reg = 4'd1;
		max_len_reg = 4'd1;
		space_reg = 63'd1;
		fails = 0;
	endfunction

	function void set_reg(int idx, bit [63:0] v);
		case (idx)
			rcw_pkg::REG_CHARS_LO, rcw_pkg::REG_CHARS_MID,
			rcw_pkg::REG_CHARS_HI, rcw_pkg::REG_CHARS_TOP: chars[idx] = v;
			rcw_pkg::REG_COUNT:   count_reg = v[5:0];
			rcw_pkg::REG_MIN_LEN: min_len_reg = v[3:0];
			rcw_pkg::REG_MAX_LEN: max_len_reg = v[3:0];
			default:              space_reg = v[62:0];
		endcase
	endfunction

	function bit [63:0] md5_head(bit [7:0] cand[8], int len);
		bit [7:0]  blk[64];
		bit [31:0] m[16];
		bit [31:0] a, b, c, d, f, tmp;
		int        g, sh;
		int        shifts[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
		blk = '{default: 8'd0};
		for (int i = 0; i < len; i++) begin
			blk[i] = cand[i];
		end
		blk[len] = 8'h80;
		blk[56] = 8'(len * 8);
		for (int i = 0; i < 16; i++) begin
			m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		end
		a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin
				f = (b & c) | (~b & d); g = i;
			end else if (i < 32) begin
				f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
			end else if (i < 48) begin
				f = b ^ c ^ d; g = (3 * i + 5) % 16;
			end else begin
				f = c ^ (b | ~d); g = (7 * i) % 16;
			end
			f = f + a + md5_const[i] + m[g];
			sh = shifts[(i / 16) * 4 + i % 4];
			tmp = d; d = c; c = b;
			b = b + ((f << sh) | (f >> (32 - sh)));
			a = tmp;
		end
		a += 32'h67452301;
		b += 32'hefcdab89;
		return {b, a};
	endfunction

	function bit [63:0] predict_end_index(bit [62:0] start_idx, bit [10:0] links_in);
		bit [63:0] idx, cnt, lo, hi, modulus, links, rest, p;
		bit [7:0]  cand[8];
		int        len, k;
		cnt = count_reg == 0 ? 1 : (count_reg > 32 ? 32 : count_reg);
		lo = min_len_reg == 0 ? 1 : (min_len_reg > 8 ? 8 : min_len_reg);
		hi = max_len_reg < lo ? lo : max_len_reg;
		if (hi > 8) begin
			hi = 8;
		end
		modulus = space_reg == 0 ? 1 : space_reg;
		links = links_in > 1024 ? 1024 : links_in;
		idx = start_idx;
		for (bit [63:0] t = 1; t < links; t++) begin
			len = int'(lo);
			rest = idx;
			forever begin
				// cnt^len stays below 2^41, so no saturation is needed here.
				p = 1;
				for (int i = 0; i < len; i++) begin
					p = p * cnt;
				end
				if (rest < p || len >= hi) begin
					break;
				end
				rest -= p;
				len++;
			end
			for (int i = 0; i < len; i++) begin
				k = int'(rest % cnt) & 31;
				cand[len - 1 - i] = chars[k / 8][8 * (k % 8) +: 8];
				rest /= cnt;
			end
			idx = (md5_head(cand, len) + t) % modulus;
		end
		return idx;
	endfunction

	function void note_item(bit [62:0] start_idx, bit [10:0] links);
		expected_ends.push_back(63'(predict_end_index(start_idx, links)));
	endfunction

	function void check_result(bit [62:0] got);
		bit [62:0] want;
		if (expected_ends.size() == 0) begin
			$display("%0t: end_index %h arrived with nothing expected", $time, got);
			fails++;
			return;
		end
		want = expected_ends.pop_front();
		if (got !== want) begin
			$display("%0t: end_index expected %h actual %h", $time, want, got);
			fails++;
		end
	endfunction
endclass

module tb;
	import rcw_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [62:0] start_index = '0;
	logic [10:0] chain_length = '0;
	logic        done;
	logic [62:0] end_index;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	chain_scoreboard sb = new();
	int gap_pct = 9;

	rainbow_chain_walk_md5 dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(end_index);
		end
	end

	initial begin
		#1_000_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic reg_write(logic [2:0] idx, logic [63:0] v);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0;
		paddr = 6'(idx) << 3;
		pwdata = v;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic send_chain(logic [62:0] idx, logic [10:0] links);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
		end
		start = 1;
		start_index = idx;
		chain_length = links;
		do @(posedge clk); while (busy);
		sb.note_item(idx, links);
		@(negedge clk);
		start = 0;
	endtask

	task automatic drain();
		while (sb.expected_ends.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic [5:0] cnt, logic [3:0] lo, logic [3:0] hi, logic [62:0] sp);
		reg_write(REG_CHARS_LO, {$urandom, $urandom});
		reg_write(REG_CHARS_MID, {$urandom, $urandom});
		reg_write(REG_CHARS_HI, {$urandom, $urandom});
		reg_write(REG_CHARS_TOP, {$urandom, $urandom});
		reg_write(REG_COUNT, 64'(cnt));
		reg_write(REG_MIN_LEN, 64'(lo));
		reg_write(REG_MAX_LEN, 64'(hi));
		reg_write(REG_SPACE, 64'(sp));
	endtask

	function automatic logic [62:0] space_of(int cnt, int lo, int hi);
		logic [62:0] sum, p;
		sum = 0;
		for (int l = lo; l <= hi; l++) begin
			p = 1;
			for (int i = 0; i < l; i++) begin
				p = p * cnt;
			end
			sum += p;
		end
		return sum;
	endfunction

	function automatic logic [62:0] rand_index();
		return 63'({$urandom, $urandom});
	endfunction

	initial begin
		int cnt, lo, hi, sel;
		logic [62:0] sp;
		logic [10:0] links;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset settings: every link collapses to index zero.
		send_chain('0, 11'd0);
		send_chain('1, 11'd1);
		send_chain('1, 11'd2);
		send_chain(63'd5, 11'd3);
		drain();

		// Full alphabet, widest lengths, largest space; one chain at the cap and one above it.
		set_config(6'd32, 4'd1, 4'd8, '1);
		send_chain('1, 11'd1024);
		send_chain(63'h2AAA_AAAA_AAAA_AAAA, 11'd2047);
		send_chain('0, 11'd7);
		send_chain(63'd40, 11'd6);
		drain();

		// Out-of-range registers: count 0, length bounds 0 and 15, space 0.
		set_config(6'd0, 4'd0, 4'd15, '0);
		send_chain('1, 11'd5);
		send_chain(63'd3, 11'd4);
		drain();

		// Count above the alphabet, min above max, index far beyond the space.
		set_config(6'd63, 4'd15, 4'd2, 63'd1000);
		send_chain('1, 11'd6);
		send_chain(63'h5555_5555_5555_5555, 11'd3);
		drain();
		set_config(6'd1, 4'd3, 4'd5, space_of(1, 3, 5));
		send_chain(63'd2, 11'd4);
		send_chain(63'd9, 11'd4);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			gap_pct = ph < 4 ? 9 : (ph < 8 ? 57 : 0);
			cnt = $urandom_range(1, 32);
			lo = $urandom_range(1, 4);
			hi = $urandom_range(lo, lo + 4 > 8 ? 8 : lo + 4);
			sel = $urandom_range(0, 3);
			sp = sel == 0 ? 63'({$urandom, $urandom}) : space_of(cnt, lo, hi);
			if (sel == 1) begin
				sp = 63'($urandom_range(1, 50));
			end
			set_config(6'(cnt), 4'(lo), 4'(hi), sp);
			for (int i = 0; i < 8; i++) begin
				links = 11'($urandom_range(0, 12));
				if ($urandom_range(0, 99) == 0) begin
					links = 11'($urandom_range(13, 300));
				end
				send_chain($urandom_range(0, 1) ? rand_index() : 63'($urandom_range(0, 2000)),
					links);
			end
			// Hold the next beats back until the block has answered everything.
			drain();
		end

		drain();
		repeat (300) @(posedge clk);
		if (sb.fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
